// ----- sv/rsnh_pkg.sv -----
package rsnh_pkg;

    // default build values
    localparam int MAX_SPHERES_DEF  = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int WORDS_PER_SPHERE = 12;

    // request function codes
    localparam logic [1:0] FUNC_LOAD    = 2'd0;
    localparam logic [1:0] FUNC_NEAREST = 2'd1;
    localparam logic [1:0] FUNC_SHADOW  = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         sphere_slot;
        logic [3:0]         word_slot;
        logic signed [31:0] word_value;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [30:0]        near_limit;
        logic [4:0]         skip_index;
    } req_item_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  nearest_index;
        logic [30:0] hit_distance;
        logic        blocked;
    } rsp_item_t;

endpackage

// ----- sv/rsnh_if.sv -----
interface rsnh_req_if;
    logic                  valid;
    logic                  ready;
    rsnh_pkg::req_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsnh_rsp_if;
    logic                  valid;
    logic                  ready;
    rsnh_pkg::rsp_item_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ray_sphere_nearest_hit.sv -----
// a load transfer gives no result
// a ray query walks the spheres in order: a skipped sphere is passed over, each other sphere
//   is mapped and dropped when the mapped direction is zero, else given a wide product and,
//   unless the discriminant misses, a square root and up to two divisions
// one query at a time, set by the shared multiplier and the shared compare-subtract step
// rst_n clears the sequencer, count_reg and the result flag; the matrix store is not cleared
module ray_sphere_nearest_hit #(
    parameter int MAX_SPHERES = rsnh_pkg::MAX_SPHERES_DEF,
    parameter int FRAC_BITS   = rsnh_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rsnh_req_if.sink    req,
    rsnh_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    // sizes derived from the sphere table depth
    localparam int IW     = $clog2(MAX_SPHERES + 1);
    localparam int DEPTH  = MAX_SPHERES * rsnh_pkg::WORDS_PER_SPHERE;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = ((IW > 4) ? IW : 4) + 4;
    localparam int CW     = (IW > 5) ? IW : 5;
    localparam int SAT_SH = 32 - FRAC_BITS;

    // fixed point constants
    localparam logic [63:0] ONE_SQ          = 64'd1 << (2 * FRAC_BITS);
    localparam logic [32:0] ONE_FIX         = 33'd1 << FRAC_BITS;
    localparam int          SHADOW_NEAR_INT = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam logic [32:0] SHADOW_NEAR     = 33'(SHADOW_NEAR_INT);
    localparam logic [32:0] ROOT_SAT        = 33'd1 << 32;

    // sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SPH  = 5'd1;
    localparam logic [4:0] S_RD   = 5'd2;
    localparam logic [4:0] S_MO   = 5'd3;
    localparam logic [4:0] S_MD   = 5'd4;
    localparam logic [4:0] S_ACD  = 5'd5;
    localparam logic [4:0] S_TR   = 5'd6;
    localparam logic [4:0] S_Q0   = 5'd7;
    localparam logic [4:0] S_Q1   = 5'd8;
    localparam logic [4:0] S_Q2   = 5'd9;
    localparam logic [4:0] S_Q3   = 5'd10;
    localparam logic [4:0] S_ABS  = 5'd11;
    localparam logic [4:0] S_WM   = 5'd12;
    localparam logic [4:0] S_DISC = 5'd13;
    localparam logic [4:0] S_SQRT = 5'd14;
    localparam logic [4:0] S_NUM  = 5'd15;
    localparam logic [4:0] S_DSEL = 5'd16;
    localparam logic [4:0] S_DSAT = 5'd17;
    localparam logic [4:0] S_DIV  = 5'd18;
    localparam logic [4:0] S_TEST = 5'd19;
    localparam logic [4:0] S_NEXT = 5'd20;
    localparam logic [4:0] S_DONE = 5'd21;

    // control state
    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [4:0] count_reg;
    logic       rsp_valid_reg;

    // query registers
    logic               shadow_reg;
    logic signed [31:0] o_reg [3];
    logic signed [31:0] d_reg [3];
    logic [32:0]        lim_reg;
    logic [4:0]         skip_reg;
    logic [IW-1:0]      idx_reg;
    logic [3:0]         w_reg;

    // matrix store and its registered read
    logic [31:0]        mem [DEPTH];
    logic signed [31:0] word_reg;
    logic [XW-1:0]      rd_addr_full;
    logic [XW-1:0]      wr_addr_full;
    logic               mem_we;

    // shared multiplier
    logic signed [32:0] mul_x;
    logic signed [32:0] mul_y;
    logic signed [65:0] mul_reg;

    // mapping and quadratic coefficients
    logic signed [65:0] po_acc_reg;
    logic signed [65:0] pd_acc_reg;
    logic signed [31:0] po_sat_reg;
    logic signed [31:0] pd_sat_reg;
    logic [63:0]        a_reg;
    logic [63:0]        ss_reg;
    logic signed [65:0] b_reg;
    logic signed [65:0] b_neg;
    logic signed [65:0] word_ext;
    logic               bneg_reg;
    logic [63:0]        bm_reg;
    logic               cpos_reg;
    logic [63:0]        cm_reg;

    // wide products from partial products
    logic [3:0]   pp_reg;
    logic [2:0]   pp_sel_reg;
    logic [63:0]  pp_x;
    logic [63:0]  pp_y;
    logic [1:0]   pp_pos;
    logic [127:0] pp_shifted;
    logic [127:0] b2_reg;
    logic [127:0] ac_reg;

    // square root and division
    logic [127:0] sq_x_reg;
    logic [65:0]  sq_rem_reg;
    logic [63:0]  sq_root_reg;
    logic [5:0]   step_cnt_reg;
    logic [63:0]  n1_reg;
    logic [63:0]  n2_reg;
    logic         ok1_reg;
    logic         ok2_reg;
    logic [63:0]  num_reg;
    logic [63:0]  dv_rem_reg;
    logic [31:0]  dv_q_reg;
    logic         dv_sat_reg;
    logic [32:0]  t_val;
    logic         div_sat;

    // shared compare-subtract step
    logic [67:0] step_a;
    logic [67:0] step_b;
    logic [67:0] step_diff;
    logic        step_ge;

    // running best
    logic          found_reg;
    logic [32:0]   best_reg;
    logic [IW-1:0] best_i_reg;
    logic          blocked_reg;

    rsnh_pkg::rsp_item_t rsp_data_reg;

    // loop decisions
    logic sph_end;
    logic sph_skip;
    logic disc_miss;
    logic query_start;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (!v[65] && (|v[64:31])) r = 32'sh7fffffff;
        else if (v[65] && !(&v[64:31])) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    assign query_start = req.valid && (state_reg == S_IDLE)
                         && (req.data.func == rsnh_pkg::FUNC_NEAREST
                             || req.data.func == rsnh_pkg::FUNC_SHADOW);

    // sphere walk ends at the count, the table depth or a shadow hit
    assign sph_end  = (CW'(idx_reg) >= CW'(count_reg))
                      || (CW'(idx_reg) >= CW'(MAX_SPHERES))
                      || (shadow_reg && blocked_reg);
    assign sph_skip = shadow_reg && (CW'(idx_reg) == CW'(skip_reg));

    assign disc_miss = cpos_reg && (b2_reg < ac_reg);

    // root as seen by the test, saturated at two to the 32
    assign t_val   = dv_sat_reg ? ROOT_SAT : {1'b0, dv_q_reg};
    assign div_sat = {32'd0, num_reg} >= ({32'd0, a_reg} << SAT_SH);

    // table addresses, sphere times twelve plus word
    assign rd_addr_full = XW'({idx_reg, 3'b000}) + XW'({idx_reg, 2'b00}) + XW'(w_reg);
    assign wr_addr_full = XW'({req.data.sphere_slot, 3'b000})
                          + XW'({req.data.sphere_slot, 2'b00})
                          + XW'(req.data.word_slot);
    assign mem_we = req.valid && (state_reg == S_IDLE)
                    && (req.data.func == rsnh_pkg::FUNC_LOAD)
                    && (req.data.word_slot < 4'd12)
                    && (XW'(req.data.sphere_slot) < XW'(MAX_SPHERES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr_full[AW-1:0]] <= req.data.word_value;
        end
        word_reg <= mem[rd_addr_full[AW-1:0]];
    end

    // multiplier operand selection
    assign pp_x = pp_reg[2] ? a_reg : bm_reg;
    assign pp_y = pp_reg[2] ? cm_reg : bm_reg;

    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        case (state_reg)
            S_MO:
            begin
                mul_x = 33'(word_reg);
                mul_y = 33'(o_reg[w_reg[1:0]]);
            end
            S_MD:
            begin
                mul_x = 33'(word_reg);
                mul_y = 33'(d_reg[w_reg[1:0]]);
            end
            S_Q0:
            begin
                mul_x = 33'(pd_sat_reg);
                mul_y = 33'(pd_sat_reg);
            end
            S_Q1:
            begin
                mul_x = 33'(po_sat_reg);
                mul_y = 33'(po_sat_reg);
            end
            S_Q2:
            begin
                mul_x = 33'(po_sat_reg);
                mul_y = 33'(pd_sat_reg);
            end
            S_WM:
            begin
                mul_x = {1'b0, (pp_reg[0] ? pp_x[63:32] : pp_x[31:0])};
                mul_y = {1'b0, (pp_reg[1] ? pp_y[63:32] : pp_y[31:0])};
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    // partial product placed at 0, 32 or 64
    assign pp_pos     = {1'b0, pp_sel_reg[0]} + {1'b0, pp_sel_reg[1]};
    assign pp_shifted = {64'd0, mul_reg[63:0]} << {pp_pos, 5'b00000};

    // compare-subtract shared by square root and division
    always_comb
    begin
        if (state_reg == S_SQRT)
        begin
            step_a = {sq_rem_reg, sq_x_reg[127:126]};
            step_b = {2'b00, sq_root_reg, 2'b01};
        end
        else
        begin
            step_a = {3'b000, dv_rem_reg, dv_q_reg[31]};
            step_b = {4'b0000, a_reg};
        end
    end
    assign step_diff = step_a - step_b;
    assign step_ge   = step_a >= step_b;

    assign b_neg    = -b_reg;
    assign word_ext = 66'(word_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (query_start) state_next = S_SPH;
            S_SPH:
            begin
                if (sph_end) state_next = S_DONE;
                else if (sph_skip) state_next = S_NEXT;
                else state_next = S_RD;
            end
            S_RD:   state_next = (w_reg[1:0] == 2'd3) ? S_TR : S_MO;
            S_MO:   state_next = S_MD;
            S_MD:   state_next = S_ACD;
            S_ACD:  state_next = S_RD;
            S_TR:   state_next = S_Q0;
            S_Q0:   state_next = S_Q1;
            S_Q1:   state_next = S_Q2;
            S_Q2:   state_next = S_Q3;
            S_Q3:   state_next = (w_reg == 4'd11) ? S_ABS : S_RD;
            S_ABS:  state_next = (a_reg == 64'd0) ? S_NEXT : S_WM;
            S_WM:   if (pp_reg == 4'd8) state_next = S_DISC;
            S_DISC: state_next = disc_miss ? S_NEXT : S_SQRT;
            S_SQRT: if (step_cnt_reg == 6'd63) state_next = S_NUM;
            S_NUM:  state_next = S_DSEL;
            S_DSEL: state_next = (ok1_reg || ok2_reg) ? S_DSAT : S_NEXT;
            S_DSAT: state_next = div_sat ? S_TEST : S_DIV;
            S_DIV:  if (step_cnt_reg == 6'd31) state_next = S_TEST;
            S_TEST: state_next = (t_val > lim_reg) ? S_NEXT : S_DSEL;
            S_NEXT: state_next = S_SPH;
            S_DONE: if (!rsp_valid_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (state_reg == S_DONE && !rsp_valid_reg)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_x * mul_y;
        case (state_reg)
            S_IDLE:
            begin
                if (query_start)
                begin
                    shadow_reg  <= (req.data.func == rsnh_pkg::FUNC_SHADOW);
                    o_reg[0]    <= req.data.origin_x;
                    o_reg[1]    <= req.data.origin_y;
                    o_reg[2]    <= req.data.origin_z;
                    d_reg[0]    <= req.data.dir_x;
                    d_reg[1]    <= req.data.dir_y;
                    d_reg[2]    <= req.data.dir_z;
                    lim_reg     <= (req.data.func == rsnh_pkg::FUNC_SHADOW)
                                   ? SHADOW_NEAR : {2'b00, req.data.near_limit};
                    skip_reg    <= req.data.skip_index;
                    idx_reg     <= '0;
                    found_reg   <= 1'b0;
                    best_reg    <= '0;
                    best_i_reg  <= '0;
                    blocked_reg <= 1'b0;
                end
            end
            S_SPH:
            begin
                w_reg      <= '0;
                po_acc_reg <= '0;
                pd_acc_reg <= '0;
                a_reg      <= '0;
                ss_reg     <= '0;
                b_reg      <= '0;
            end
            S_MD:
            begin
                po_acc_reg <= po_acc_reg + (mul_reg >>> FRAC_BITS);
            end
            S_ACD:
            begin
                pd_acc_reg <= pd_acc_reg + (mul_reg >>> FRAC_BITS);
                w_reg      <= w_reg + 4'd1;
            end
            S_TR:
            begin
                // add translation, clamp each mapped component
                po_sat_reg <= sat32(po_acc_reg + word_ext);
                pd_sat_reg <= sat32(pd_acc_reg);
            end
            S_Q1: a_reg  <= a_reg + mul_reg[63:0];
            S_Q2: ss_reg <= ss_reg + mul_reg[63:0];
            S_Q3:
            begin
                b_reg      <= b_reg + mul_reg;
                po_acc_reg <= '0;
                pd_acc_reg <= '0;
                w_reg      <= w_reg + 4'd1;
            end
            S_ABS:
            begin
                bneg_reg <= b_reg[65];
                bm_reg   <= b_reg[65] ? b_neg[63:0] : b_reg[63:0];
                cpos_reg <= ss_reg >= ONE_SQ;
                cm_reg   <= (ss_reg >= ONE_SQ) ? ss_reg - ONE_SQ : ONE_SQ - ss_reg;
                pp_reg   <= '0;
                b2_reg   <= '0;
                ac_reg   <= '0;
            end
            S_WM:
            begin
                // issue one partial product, fold in the previous one
                pp_sel_reg <= pp_reg[2:0];
                pp_reg     <= pp_reg + 4'd1;
                if (pp_reg != 4'd0)
                begin
                    if (pp_sel_reg[2]) ac_reg <= ac_reg + pp_shifted;
                    else b2_reg <= b2_reg + pp_shifted;
                end
            end
            S_DISC:
            begin
                sq_x_reg     <= cpos_reg ? b2_reg - ac_reg : b2_reg + ac_reg;
                sq_rem_reg   <= '0;
                sq_root_reg  <= '0;
                step_cnt_reg <= '0;
            end
            S_SQRT:
            begin
                // one root bit a step
                sq_x_reg     <= {sq_x_reg[125:0], 2'b00};
                step_cnt_reg <= step_cnt_reg + 6'd1;
                if (step_ge)
                begin
                    sq_rem_reg  <= step_diff[65:0];
                    sq_root_reg <= {sq_root_reg[62:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg  <= step_a[65:0];
                    sq_root_reg <= {sq_root_reg[62:0], 1'b0};
                end
            end
            S_NUM:
            begin
                // numerators of both roots, sums wrap at 64 bits
                ok1_reg <= 1'b0;
                ok2_reg <= 1'b0;
                n1_reg  <= '0;
                n2_reg  <= '0;
                if (bneg_reg || bm_reg == 64'd0)
                begin
                    n1_reg  <= bm_reg + sq_root_reg;
                    ok1_reg <= (bm_reg + sq_root_reg) != 64'd0;
                    n2_reg  <= bm_reg - sq_root_reg;
                    ok2_reg <= bm_reg > sq_root_reg;
                end
                else if (sq_root_reg > bm_reg)
                begin
                    n1_reg  <= sq_root_reg - bm_reg;
                    ok1_reg <= 1'b1;
                end
            end
            S_DSEL:
            begin
                // smaller root first
                if (ok2_reg)
                begin
                    num_reg <= n2_reg;
                    ok2_reg <= 1'b0;
                end
                else if (ok1_reg)
                begin
                    num_reg <= n1_reg;
                    ok1_reg <= 1'b0;
                end
            end
            S_DSAT:
            begin
                dv_sat_reg   <= div_sat;
                dv_rem_reg   <= num_reg >> SAT_SH;
                dv_q_reg     <= num_reg[31:0] << FRAC_BITS;
                step_cnt_reg <= '0;
            end
            S_DIV:
            begin
                // one quotient bit a step, shifting into the low word
                step_cnt_reg <= step_cnt_reg + 6'd1;
                dv_q_reg     <= {dv_q_reg[30:0], step_ge};
                dv_rem_reg   <= step_ge ? step_diff[63:0] : step_a[63:0];
            end
            S_TEST:
            begin
                if (t_val > lim_reg)
                begin
                    if (shadow_reg)
                    begin
                        if (t_val <= ONE_FIX) blocked_reg <= 1'b1;
                    end
                    else if (!found_reg || t_val < best_reg)
                    begin
                        found_reg  <= 1'b1;
                        best_reg   <= t_val;
                        best_i_reg <= idx_reg;
                    end
                end
            end
            S_NEXT: idx_reg <= idx_reg + IW'(1);
            S_DONE:
            begin
                if (!rsp_valid_reg)
                begin
                    rsp_data_reg.hit           <= found_reg;
                    rsp_data_reg.nearest_index <= found_reg ? 4'(best_i_reg) : 4'd0;
                    rsp_data_reg.hit_distance  <= (|best_reg[32:31]) ? 31'h7fffffff
                                                                     : best_reg[30:0];
                    rsp_data_reg.blocked       <= blocked_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

// ----- sv/rsnh_checker.sv -----
module rsnh_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic [1:0]          req_func,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input rsnh_pkg::rsp_item_t rsp_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // a miss reports no index and no distance
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.hit |-> rsp_data.nearest_index == 4'd0
                                       && rsp_data.hit_distance == 31'd0)
        else $error("miss with index or distance");

    // blocked results never claim a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.blocked |-> !rsp_data.hit)
        else $error("blocked and hit together");

    // a query transfer makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_func == rsnh_pkg::FUNC_NEAREST
                                   || req_func == rsnh_pkg::FUNC_SHADOW)
        |=> !req_ready)
        else $error("ready after query transfer");

endmodule

bind ray_sphere_nearest_hit rsnh_checker u_rsnh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_func  (req.data.func),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
